// ===== hdl/vrsp_pkg.sv =====
// vrsp_pkg: shared types and constants for the varint record stream parser.
// No dependencies; used by every module of the block.
package vrsp_pkg;

  // Result kinds as seen on the result channel
  typedef enum logic [1:0] {
    KIND_VALUE   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_EMPTY   = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_ENDED = 2'd1,
    CAUSE_LONG  = 2'd2
  } cause_t;

  // item_format register codes; the unused code decodes as varint32
  localparam logic [1:0] FMT_VAR32  = 2'd0;
  localparam logic [1:0] FMT_VAR64  = 2'd1;
  localparam logic [1:0] FMT_RECORD = 2'd2;

  localparam logic [3:0] MAX_BYTES_NARROW = 4'd5;
  localparam logic [3:0] MAX_BYTES_WIDE   = 4'd10;
  localparam logic [3:0] LAST_GROUP       = 4'd9;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    logic [7:0]  payload;
    logic        last;
    cause_t      cause;
  } result_t;

  // One queue entry: a result plus a flag that asks the back end to follow
  // it with a buffer-ended error.
  typedef struct packed {
    result_t res;
    logic    ended_after;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hdl/vrsp_if.sv =====
// vrsp_if: stream interfaces for input bytes and parser results.
// Depends on nothing; used by the top level.
interface vrsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, data_byte, end_of_buffer, input ready);
  modport sink (input valid, data_byte, end_of_buffer, output ready);
endinterface

interface vrsp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] decoded_value;
  logic [7:0]  payload_byte;
  logic        record_last;
  logic [1:0]  error_cause;

  modport source (output valid, kind, decoded_value, payload_byte, record_last, error_cause,
                  input ready);
  modport sink (input valid, kind, decoded_value, payload_byte, record_last, error_cause,
                output ready);
endinterface

// ===== hdl/vrsp_queue.sv =====
// vrsp_queue: small register FIFO of parsed entries between front and back.
// Depends on vrsp_pkg.
module vrsp_queue #(
  parameter int DEPTH = vrsp_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  vrsp_pkg::entry_t    push_entry,
  input  logic                pop,
  output vrsp_pkg::entry_t    head,
  output vrsp_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  vrsp_pkg::entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign status.full  = (count == CNT_FULL);
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/vrsp_front.sv =====
// vrsp_front: parse state machine; takes one byte a cycle while the queue is not full and pushes results.
// Depends on vrsp_pkg.
module vrsp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          item_format,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                end_of_buffer,
  input  vrsp_pkg::q_status_t q_status,
  output logic                push,
  output vrsp_pkg::entry_t    push_entry
);

  typedef enum logic [1:0] {
    PH_VARINT  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROP    = 2'd2
  } phase_t;

  phase_t      phase, phase_next;
  logic [63:0] accumulator, accumulator_next;
  logic [3:0]  byte_position, byte_position_next;
  logic [31:0] remaining, remaining_next;

  logic        accept;
  logic        wide;
  logic [3:0]  max_bytes;
  logic [3:0]  pos;
  logic [3:0]  pos_inc;
  logic [5:0]  shamt;
  logic [63:0] acc_new;
  logic [63:0] value;
  logic [31:0] rem_dec;
  logic        rec_last;

  assign in_ready  = !q_status.full;
  assign accept    = in_valid && in_ready;
  assign wide      = (item_format == vrsp_pkg::FMT_VAR64);
  assign max_bytes = wide ? vrsp_pkg::MAX_BYTES_WIDE : vrsp_pkg::MAX_BYTES_NARROW;
  assign pos       = (byte_position > vrsp_pkg::LAST_GROUP) ? vrsp_pkg::LAST_GROUP
                                                            : byte_position;
  assign pos_inc   = pos + 4'd1;
  // 7 * pos, at most 63
  assign shamt     = 6'({pos, 3'b000} - {3'b000, pos});
  assign acc_new   = accumulator | ({57'd0, data_byte[6:0]} << shamt);
  assign value     = wide ? acc_new : {32'd0, acc_new[31:0]};
  assign rem_dec   = (remaining != '0) ? remaining - 32'd1 : remaining;
  assign rec_last  = (rem_dec == '0);

  always_comb begin
    phase_next         = phase;
    accumulator_next   = accumulator;
    byte_position_next = byte_position;
    remaining_next     = remaining;
    push               = 1'b0;
    push_entry         = '0;

    if (accept) begin
      unique case (phase)
        PH_DROP: begin
          if (end_of_buffer) begin
            phase_next = PH_VARINT;
          end
        end
        PH_PAYLOAD: begin
          push                   = 1'b1;
          push_entry.res.kind    = vrsp_pkg::KIND_PAYLOAD;
          push_entry.res.payload = data_byte;
          push_entry.res.last    = rec_last;
          if (rec_last || end_of_buffer) begin
            push_entry.ended_after = !rec_last;
            phase_next             = PH_VARINT;
            remaining_next         = '0;
          end else begin
            remaining_next = rem_dec;
          end
        end
        default: begin
          accumulator_next   = '0;
          byte_position_next = '0;
          remaining_next     = '0;
          if (!data_byte[7]) begin
            if (item_format == vrsp_pkg::FMT_RECORD) begin
              if (value[31:0] == '0) begin
                push                = 1'b1;
                push_entry.res.kind = vrsp_pkg::KIND_EMPTY;
              end else if (end_of_buffer) begin
                push                 = 1'b1;
                push_entry.res.kind  = vrsp_pkg::KIND_ERROR;
                push_entry.res.cause = vrsp_pkg::CAUSE_ENDED;
              end else begin
                remaining_next = value[31:0];
                phase_next     = PH_PAYLOAD;
              end
            end else begin
              push                 = 1'b1;
              push_entry.res.kind  = vrsp_pkg::KIND_VALUE;
              push_entry.res.value = value;
            end
          end else if (pos_inc >= max_bytes) begin
            push                 = 1'b1;
            push_entry.res.kind  = vrsp_pkg::KIND_ERROR;
            push_entry.res.cause = vrsp_pkg::CAUSE_LONG;
            if (!end_of_buffer) begin
              phase_next = PH_DROP;
            end
          end else if (end_of_buffer) begin
            push                 = 1'b1;
            push_entry.res.kind  = vrsp_pkg::KIND_ERROR;
            push_entry.res.cause = vrsp_pkg::CAUSE_ENDED;
          end else begin
            accumulator_next   = acc_new;
            byte_position_next = pos_inc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_VARINT;
      accumulator   <= '0;
      byte_position <= '0;
      remaining     <= '0;
    end else begin
      phase         <= phase_next;
      accumulator   <= accumulator_next;
      byte_position <= byte_position_next;
      remaining     <= remaining_next;
    end
  end

endmodule

// ===== hdl/vrsp_back.sv =====
// vrsp_back: drains the queue into the registered result output, adding the
// trailing buffer-ended error where an entry asks for one. Depends on vrsp_pkg.
module vrsp_back (
  input  logic                clk,
  input  logic                rst,
  input  vrsp_pkg::entry_t    head,
  input  vrsp_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output vrsp_pkg::result_t   out_res
);

  logic load;
  logic pend_err;

  assign load = !out_valid || out_ready;
  assign pop  = load && !pend_err && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_err  <= 1'b0;
    end else if (load) begin
      if (pend_err) begin
        out_valid <= 1'b1;
        pend_err  <= 1'b0;
      end else begin
        out_valid <= !q_status.empty;
        pend_err  <= !q_status.empty && head.ended_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_err) begin
        out_res <= '{kind:    vrsp_pkg::KIND_ERROR,
                     value:   64'd0,
                     payload: 8'd0,
                     last:    1'b0,
                     cause:   vrsp_pkg::CAUSE_ENDED};
      end else begin
        out_res <= head.res;
      end
    end
  end

endmodule

// ===== hdl/varint_record_stream_parser.sv =====
// varint_record_stream_parser: top level of the base-128 varint / record parser.
// Depends on vrsp_pkg, vrsp_if, vrsp_front, vrsp_queue and vrsp_back.
//
//   channel    dir  handshake            payload
//   ---------  ---  -------------------  ------------------------------------------
//   bytes      in   valid/ready          data_byte[7:0], end_of_buffer
//   results    out  valid/ready          kind, decoded_value[63:0], payload_byte,
//                                        record_last, error_cause
//   cfg        in   cfg_write            cfg_data[1:0] -> item_format
//
// Throughput is one byte per clock while the queue has room: the front end does
// a whole parse step per byte (one 7-bit group shift into the 64-bit accumulator)
// and pushes at most one queue entry. Results leave at one per clock while
// results.ready is high; a byte that ends a buffer in mid payload yields two
// results, the error after the payload. Entries go through the queue to the
// output register. Reset clears parse state, the queue and the output register;
// item_format resets to varint32. Bytes stall only when the queue is full.
module varint_record_stream_parser #(
  parameter int QUEUE_DEPTH = vrsp_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_data,
  vrsp_byte_if.sink     bytes,
  vrsp_result_if.source results
);

  logic [1:0]          item_format;
  logic                push;
  logic                pop;
  vrsp_pkg::entry_t    push_entry;
  vrsp_pkg::entry_t    head;
  vrsp_pkg::q_status_t q_status;
  vrsp_pkg::result_t   out_res;
  logic                out_valid;
  logic                in_ready;

  // Format register; the user must write it only while the parser is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_format <= vrsp_pkg::FMT_VAR32;
    end else if (cfg_write) begin
      item_format <= cfg_data;
    end
  end

  // Front end: parse state, classification of each byte.
  vrsp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .item_format   (item_format),
    .in_valid      (bytes.valid),
    .in_ready      (in_ready),
    .data_byte     (bytes.data_byte),
    .end_of_buffer (bytes.end_of_buffer),
    .q_status      (q_status),
    .push          (push),
    .push_entry    (push_entry)
  );

  assign bytes.ready = in_ready;

  // Decoupling queue between parse and output.
  vrsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // Back end: output register, expands entries that carry a trailing error.
  vrsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (results.ready),
    .out_res   (out_res)
  );

  assign results.valid         = out_valid;
  assign results.kind          = out_res.kind;
  assign results.decoded_value = out_res.value;
  assign results.payload_byte  = out_res.payload;
  assign results.record_last   = out_res.last;
  assign results.error_cause   = out_res.cause;

endmodule

// ===== bench/vrsp_result_checker.sv =====
`timescale 1ns / 100ps
// vrsp_result_checker: watches the byte and result channels of the varint parser,
// predicts every result from the accepted bytes and compares them in order.
// Depends on vrsp_pkg.
module vrsp_result_checker
  import vrsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_data,
  input  logic        byte_valid,
  input  logic        byte_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  input  logic        res_valid,
  input  logic        res_ready,
  input  logic [1:0]  kind,
  input  logic [63:0] decoded_value,
  input  logic [7:0]  payload_byte,
  input  logic        record_last,
  input  logic [1:0]  error_cause,
  output int          fail_count,
  output int          pending,
  output int          bytes_seen,
  output int          results_seen
);

  localparam int MAX_REPORTS = 10;

  typedef enum logic [1:0] {
    PH_VARINT  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROP    = 2'd2
  } parse_phase_t;

  // predictor state
  logic [63:0]  acc;
  logic [3:0]   grp;
  parse_phase_t parse_phase;
  logic [31:0]  remaining;
  logic [1:0]   fmt_reg;

  result_t due_results[$];
  result_t got, want;
  int      errors = 0;
  int      n_bytes = 0;
  int      n_results = 0;

  task automatic emit(input kind_t k, input logic [63:0] v, input logic [7:0] p,
                      input logic l, input cause_t c);
    result_t r;
    r.kind    = k;
    r.value   = v;
    r.payload = p;
    r.last    = l;
    r.cause   = c;
    due_results.push_back(r);
  endtask

  task automatic clear_parse();
    acc         = '0;
    grp         = '0;
    parse_phase = PH_VARINT;
    remaining   = '0;
  endtask

  // one parse step per accepted word
  task automatic parse_byte(input logic [7:0] b, input logic eob);
    logic        wide;
    logic [3:0]  limit;
    logic [3:0]  slot;
    logic [63:0] val;
    case (parse_phase)
      PH_DROP: begin
        if (eob) clear_parse();
      end
      PH_PAYLOAD: begin
        if (remaining != 0) remaining = remaining - 1;
        emit(KIND_PAYLOAD, 64'd0, b, remaining == 0, CAUSE_NONE);
        if (remaining == 0) begin
          clear_parse();
        end else if (eob) begin
          emit(KIND_ERROR, 64'd0, 8'd0, 1'b0, CAUSE_ENDED);
          clear_parse();
        end
      end
      default: begin
        wide  = (fmt_reg == FMT_VAR64);
        limit = wide ? MAX_BYTES_WIDE : MAX_BYTES_NARROW;
        slot  = (grp > LAST_GROUP) ? LAST_GROUP : grp;
        acc   = acc | ({57'd0, b[6:0]} << (7 * slot));
        if (!b[7]) begin
          val = wide ? acc : {32'd0, acc[31:0]};
          if (fmt_reg == FMT_RECORD) begin
            if (val == 0) begin
              emit(KIND_EMPTY, 64'd0, 8'd0, 1'b0, CAUSE_NONE);
              clear_parse();
            end else begin
              acc         = '0;
              grp         = '0;
              remaining   = val[31:0];
              parse_phase = PH_PAYLOAD;
              if (eob) begin
                emit(KIND_ERROR, 64'd0, 8'd0, 1'b0, CAUSE_ENDED);
                clear_parse();
              end
            end
          end else begin
            emit(KIND_VALUE, val, 8'd0, 1'b0, CAUSE_NONE);
            clear_parse();
          end
        end else begin
          slot = slot + 4'd1;
          if (slot >= limit) begin
            emit(KIND_ERROR, 64'd0, 8'd0, 1'b0, CAUSE_LONG);
            clear_parse();
            if (!eob) parse_phase = PH_DROP;
          end else if (eob) begin
            emit(KIND_ERROR, 64'd0, 8'd0, 1'b0, CAUSE_ENDED);
            clear_parse();
          end else begin
            grp = slot;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      fmt_reg = FMT_VAR32;
      due_results.delete();
    end else begin
      // results first: a word accepted this edge passes the queue and the output register before its result shows up
      if (res_valid && res_ready) begin
        n_results++;
        got.kind    = kind_t'(kind);
        got.value   = decoded_value;
        got.payload = payload_byte;
        got.last    = record_last;
        got.cause   = cause_t'(error_cause);
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("ERROR unexpected result: kind %0d value %h byte %h last %0d cause %0d",
                     got.kind, got.value, got.payload, got.last, got.cause);
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind || got.value !== want.value ||
              got.payload !== want.payload || got.last !== want.last ||
              got.cause !== want.cause) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("ERROR result %0d: expected kind %0d value %h byte %h last %0d ",
                       n_results, want.kind, want.value, want.payload, want.last,
                       "cause %0d, got kind %0d value %h byte %h last %0d cause %0d",
                       want.cause, got.kind, got.value, got.payload, got.last, got.cause);
          end
        end
      end
      if (byte_valid && byte_ready) begin
        n_bytes++;
        parse_byte(data_byte, end_of_buffer);
      end
      if (cfg_write) fmt_reg = cfg_data;
    end
    fail_count   <= errors;
    pending      <= due_results.size();
    bytes_seen   <= n_bytes;
    results_seen <= n_results;
  end

endmodule

// ===== bench/varint_record_stream_parser_tb.sv =====
`timescale 1ns / 100ps
// varint_record_stream_parser_tb: drives bytes and format writes into the parser,
// throttles both channels and gives the verdict; checking lives in vrsp_result_checker.
// Depends on vrsp_pkg, vrsp_if, vrsp_result_checker and the parser RTL.
module varint_record_stream_parser_tb;
  import vrsp_pkg::*;

  localparam int         CLK_PERIOD     = 10;
  localparam int         RESET_CYCLES   = 10;
  localparam int         SETTLE_CYCLES  = 8;     // pipeline is two deep; margin on top
  localparam int         DRAIN_CYCLES   = 20;
  localparam int         LONG_HOLD      = 64;    // far beyond the 4-entry queue
  localparam int         WATCHDOG_LIMIT = 2000;  // cycles without any handshake
  localparam int         WORDS_PER_FMT  = 33;    // 3 phases x 4 formats -> ~400 words
  localparam logic [1:0] FMT_UNUSED     = 2'd3;  // decodes as varint32

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic [1:0] cfg_data;

  vrsp_byte_if   byte_ch ();
  vrsp_result_if result_ch ();

  int fail_count;
  int pending;
  int bytes_seen;
  int results_seen;

  // throttle knobs, shared by the sender and receiver processes
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_results  = 1'b0;
  int words_sent    = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  varint_record_stream_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .bytes    (byte_ch),
    .results  (result_ch)
  );

  vrsp_result_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .byte_valid   (byte_ch.valid),
    .byte_ready   (byte_ch.ready),
    .data_byte    (byte_ch.data_byte),
    .end_of_buffer(byte_ch.end_of_buffer),
    .res_valid    (result_ch.valid),
    .res_ready    (result_ch.ready),
    .kind         (result_ch.kind),
    .decoded_value(result_ch.decoded_value),
    .payload_byte (result_ch.payload_byte),
    .record_last  (result_ch.record_last),
    .error_cause  (result_ch.error_cause),
    .fail_count   (fail_count),
    .pending      (pending),
    .bytes_seen   (bytes_seen),
    .results_seen (results_seen)
  );

  // Offer one word, idling before it at the current rate. Valid stays high on
  // return; the next call either lowers it or replaces the word in that step.
  task automatic push_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.data_byte     <= b;
    byte_ch.end_of_buffer <= eob;
    do @(posedge clk); while (!byte_ch.ready);
    words_sent++;
  endtask

  // LEB128 encode; groups above the minimal count pad with zero groups
  // (non-minimal but legal until the byte limit is hit).
  task automatic send_varint(input logic [63:0] v, input int groups, input bit eob);
    int          n;
    logic [63:0] rest;
    logic [63:0] chunk;
    n    = 1;
    rest = v >> 7;
    while (rest != 0) begin
      n++;
      rest = rest >> 7;
    end
    if (groups > n) n = groups;
    for (int i = 0; i < n; i++) begin
      chunk = v >> (7 * i);
      push_byte({i < n - 1, chunk[6:0]}, eob && (i == n - 1));
    end
  endtask

  // Length prefix plus count payload words; count below len gives a cut record.
  task automatic send_record(input logic [31:0] len, input int groups, input int count,
                             input bit eob);
    send_varint({32'd0, len}, groups, eob && count == 0);
    for (int i = 0; i < count; i++)
      push_byte(8'($urandom_range(255)), eob && i == count - 1);
  endtask

  // Format writes happen only with the parser drained: nothing owed on the
  // result side and a settle wait for words that produce no result.
  task automatic set_format(input logic [1:0] f);
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= f;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Values skewed toward group boundaries and the all-ones extremes. Narrow
  // formats mostly stay within 35 bits so that five groups suffice.
  function automatic logic [63:0] rand_value(input bit narrow);
    logic [63:0] v;
    int          k;
    case ($urandom_range(5))
      0: v = 64'($urandom_range(127));
      1: v = 64'($urandom_range(16383));
      2: v = 64'($urandom);
      3: v = narrow ? 64'h7_FFFF_FFFF : '1;
      4: v = {$urandom, $urandom};
      default: begin
        k = $urandom_range(63);
        v = (64'd1 << k) - 64'($urandom_range(1));
      end
    endcase
    if (narrow && $urandom_range(7) != 0) v = v & 64'h7_FFFF_FFFF;
    return v;
  endfunction

  // One stretch of stimulus: mostly well-formed items with random content,
  // the rest cut buffers, over-long varints and raw noise.
  task automatic random_segment(input logic [1:0] f);
    bit          narrow;
    int          limit;
    int          r;
    int          n;
    int          pad;
    bit          eob;
    logic [31:0] len;
    narrow = (f != FMT_VAR64);
    limit  = narrow ? int'(MAX_BYTES_NARROW) : int'(MAX_BYTES_WIDE);
    r      = $urandom_range(99);
    eob    = ($urandom_range(3) == 0);
    pad    = ($urandom_range(4) == 0) ? $urandom_range(1, limit) : 0;
    if (r < 72) begin
      if (f == FMT_RECORD) begin
        if ($urandom_range(15) == 0) begin
          // length wraps to zero in 32 bits: reads as an empty record
          send_varint(64'h1_0000_0000, 0, eob);
        end else begin
          len = ($urandom_range(4) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
          send_record(len, pad, int'(len), eob);
        end
      end else begin
        send_varint(rand_value(narrow), pad, eob);
      end
    end else if (r < 84) begin
      if (f == FMT_RECORD && r < 78) begin
        // buffer ends inside the payload (or right after the length)
        len = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : 32'($urandom_range(2, 9));
        send_record(len, 0, $urandom_range(0, (len > 7) ? 6 : int'(len) - 1), 1'b1);
      end else begin
        // buffer ends inside a varint
        n = $urandom_range(1, limit - 1);
        for (int i = 0; i < n; i++)
          push_byte(8'h80 | 8'($urandom_range(127)), i == n - 1);
      end
    end else if (r < 93) begin
      // over-long varint; anything past the limit is dropped up to end of buffer
      n = limit + $urandom_range(0, 3);
      for (int i = 0; i < n; i++)
        push_byte(8'h80 | 8'($urandom_range(127)), eob && i == n - 1);
      if (!eob) push_byte(8'($urandom_range(255)), 1'b1);
    end else begin
      // noise, always closed by an end of buffer so parsing restarts
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        push_byte(8'($urandom_range(255)), (i == n - 1) || ($urandom_range(3) == 0));
    end
  endtask

  // Receiver: random ready at the current rate; on request one long hold-off,
  // counted here, while the sender keeps offering words.
  initial begin : result_sink
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_results = 1'b0;
      end
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: any handshake on either channel resets the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no handshake for %0d cycles, %0d results still owed",
             WATCHDOG_LIMIT, pending);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int         send_idle[3];
    int         recv_idle[3];
    logic [1:0] fmt_seq[4];
    logic [1:0] f;
    int         target;
    send_idle = '{30, 61, 0};
    recv_idle = '{61, 30, 0};
    fmt_seq   = '{FMT_RECORD, FMT_VAR64, FMT_UNUSED, FMT_VAR32};

    rst                   <= 1'b1;
    cfg_write             <= 1'b0;
    cfg_data              <= FMT_VAR32;
    byte_ch.valid         <= 1'b0;
    byte_ch.data_byte     <= 8'd0;
    byte_ch.end_of_buffer <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = send_idle[0];
    recv_idle_pct = recv_idle[0];

    // ---- directed part ----
    set_format(FMT_VAR32);
    // five groups, top bits of the fifth group fall off: 0xFFFFFFFF
    send_varint(64'h7_FFFF_FFFF, 0, 1'b1);
    // fifth continuation word is too long; the rest of the buffer is dropped
    repeat (5) push_byte(8'h80, 1'b0);
    push_byte(8'h33, 1'b1);
    // buffer ends in the middle of a varint
    push_byte(8'h81, 1'b1);

    // unused format code parses as varint32
    set_format(FMT_UNUSED);
    push_byte(8'h7F, 1'b0);

    set_format(FMT_RECORD);
    push_byte(8'h00, 1'b0);              // zero length: empty record
    send_record(32'd2, 0, 2, 1'b0);      // full record, last mark on second word
    send_record(32'd5, 0, 1, 1'b1);      // ends mid payload: payload then error
    push_byte(8'h03, 1'b1);              // ends right after the length

    // format change in the middle of a varint: six groups taken as varint64,
    // the next continuation word is judged against the narrow limit
    set_format(FMT_VAR64);
    repeat (6) push_byte(8'h80, 1'b0);
    set_format(FMT_VAR32);
    push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b1);

    // ---- random part: three throttle phases, every format in each ----
    target = words_sent;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_idle[ph];
      recv_idle_pct = recv_idle[ph];
      for (int k = 0; k < 4; k++) begin
        f = fmt_seq[(k + ph) % 4];
        set_format(f);
        // with the sender at full rate, stall results long enough to back up
        // the queue and push back on the input
        if (ph == 2 && k == 0) hold_results = 1'b1;
        target += WORDS_PER_FMT;
        while (words_sent < target) random_segment(f);
      end
    end

    // ---- drain ----
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d words parsed, %0d results checked under all four format codes",
             bytes_seen, results_seen);
    $display("Summary: both sides throttled in turn, one long result hold-off, %0d errors",
             fail_count);
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
